// File: sv/cfpr_pkg.sv
`default_nettype none

package cfpr_pkg;

    // APB register map: register i at byte address 4*i
    localparam int ApbAddrW = 4;
    localparam int ApbDataW = 32;

    localparam logic [1:0] RegSourceId   = 2'd0;
    localparam logic [1:0] RegDestId     = 2'd1;
    localparam logic [1:0] RegFrameLimit = 2'd2;

    localparam logic [7:0] SourceIdReset   = 8'h55;
    localparam logic [7:0] DestIdReset     = 8'hAA;
    localparam logic [8:0] FrameLimitReset = 9'd261;

    // Modbus CRC-16, reflected
    localparam logic [15:0] CrcPoly = 16'hA001;
    localparam logic [15:0] CrcInit = 16'hFFFF;

    typedef struct packed {
        logic [7:0] source_id;
        logic [7:0] dest_id;
        logic [8:0] frame_limit;
    } t_cfg;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       frame_byte;
        logic       frame_start;
        logic       frame_abort;
        logic       frame_end;
        logic       crc_ok;
        logic [8:0] frame_bytes;
    } t_result;

    // One byte through the CRC, LSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: sv/crc_framed_packet_receiver_unit.sv
// Serial frame receiver with Modbus CRC-16 check. Each input item is one byte
// from the serial line; each produces exactly one result item that passes the
// byte through and flags whether it belongs to a candidate frame (source id,
// destination id, length 1..frame_limit-6, payload, CRC low then high byte).
// frame_start marks the source id byte, frame_abort a bad destination id or
// length (that byte is not retried as a source id), and frame_end the last CRC
// byte, with crc_ok and frame_bytes (payload length + 5) valid only there.
// Throughput is one item per clock while o_in_stall is low: the byte-wide CRC
// step and the parse state update are combinational. Each result is held in a
// registered output, or in one skid entry while the output is stalled; this
// keeps input accepted while a result is stalled, and o_in_stall rises only when
// both are full. Registers at APB byte addresses 0x0 source_id, 0x4 dest_id,
// 0x8 frame_limit; writes take effect from the next byte.
`default_nettype none

module crc_framed_packet_receiver_unit
    import cfpr_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // byte input
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire logic [7:0]          i_rx_byte,
    // result output
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output logic      [7:0]          o_byte_value,
    output logic                     o_frame_byte,
    output logic                     o_frame_start,
    output logic                     o_frame_abort,
    output logic                     o_frame_end,
    output logic                     o_crc_ok,
    output logic      [8:0]          o_frame_bytes,
    // APB configuration
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ApbAddrW-1:0] paddr,
    input  wire logic [ApbDataW-1:0] pwdata,
    output logic      [ApbDataW-1:0] prdata,
    output logic                     pready
);

    t_cfg    cfg;
    t_result parse_res;
    t_result out_res;
    logic    accept;

    cfpr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    cfpr_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_rx_byte (i_rx_byte),
        .i_cfg     (cfg),
        .o_result  (parse_res)
    );

    cfpr_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_accept    (accept),
        .i_result    (parse_res),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (out_res)
    );

    assign o_byte_value  = out_res.byte_value;
    assign o_frame_byte  = out_res.frame_byte;
    assign o_frame_start = out_res.frame_start;
    assign o_frame_abort = out_res.frame_abort;
    assign o_frame_end   = out_res.frame_end;
    assign o_crc_ok      = out_res.crc_ok;
    assign o_frame_bytes = out_res.frame_bytes;

endmodule

`default_nettype wire

// File: sv/cfpr_regs.sv
`default_nettype none

module cfpr_regs
    import cfpr_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ApbAddrW-1:0] paddr,
    input  wire logic [ApbDataW-1:0] pwdata,
    output logic      [ApbDataW-1:0] prdata,
    output logic                     pready,
    output t_cfg                     o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    // register writes; unmapped addresses are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.source_id   <= SourceIdReset;
            r_cfg.dest_id     <= DestIdReset;
            r_cfg.frame_limit <= FrameLimitReset;
        end else if (wr_en) begin
            case (reg_idx)
                RegSourceId:   r_cfg.source_id   <= pwdata[7:0];
                RegDestId:     r_cfg.dest_id     <= pwdata[7:0];
                RegFrameLimit: r_cfg.frame_limit <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (reg_idx)
            RegSourceId:   prdata = {24'd0, r_cfg.source_id};
            RegDestId:     prdata = {24'd0, r_cfg.dest_id};
            RegFrameLimit: prdata = {23'd0, r_cfg.frame_limit};
            default:       prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: sv/cfpr_parser.sv
`default_nettype none

module cfpr_parser
    import cfpr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_rx_byte,
    input  wire t_cfg       i_cfg,
    output t_result         o_result
);

    localparam logic [2:0] PhSrc   = 3'd0;
    localparam logic [2:0] PhDst   = 3'd1;
    localparam logic [2:0] PhLen   = 3'd2;
    localparam logic [2:0] PhData  = 3'd3;
    localparam logic [2:0] PhCrcLo = 3'd4;
    localparam logic [2:0] PhCrcHi = 3'd5;

    localparam logic [8:0] HdrBytes = 9'd3;
    localparam logic [8:0] Overhead = 9'd5;

    logic [2:0]  r_phase,  n_phase;
    logic [7:0]  r_len,    n_len;
    logic [8:0]  r_idx,    n_idx;
    logic [15:0] r_crc,    n_crc;
    logic [7:0]  r_crc_lo, n_crc_lo;

    logic [15:0] crc_in;
    logic [15:0] crc_upd;
    logic [8:0]  idx_inc;
    logic [9:0]  len_sum;
    logic        len_ok;
    t_result     res;

    // shared byte-wide CRC step; a new frame restarts from the initial value
    assign crc_in  = (r_phase == PhSrc) ? CrcInit : r_crc;
    assign crc_upd = crc_byte(crc_in, i_rx_byte);
    assign idx_inc = r_idx + 9'd1;
    assign len_sum = {2'b00, i_rx_byte} + {1'b0, Overhead};
    assign len_ok  = (i_rx_byte != 8'd0) && (len_sum < {1'b0, i_cfg.frame_limit});

    // frame hunt and per-byte verdict
    always_comb begin
        n_phase  = r_phase;
        n_len    = r_len;
        n_idx    = r_idx;
        n_crc    = r_crc;
        n_crc_lo = r_crc_lo;
        res      = '0;
        res.byte_value = i_rx_byte;
        case (r_phase)
            PhSrc: begin
                if (i_rx_byte == i_cfg.source_id) begin
                    res.frame_byte  = 1'b1;
                    res.frame_start = 1'b1;
                    n_crc   = crc_upd;
                    n_phase = PhDst;
                end
            end
            PhDst: begin
                if (i_rx_byte == i_cfg.dest_id) begin
                    res.frame_byte = 1'b1;
                    n_crc   = crc_upd;
                    n_phase = PhLen;
                end else begin
                    res.frame_abort = 1'b1;
                    n_phase = PhSrc;
                end
            end
            PhLen: begin
                if (len_ok) begin
                    res.frame_byte = 1'b1;
                    n_crc   = crc_upd;
                    n_len   = i_rx_byte;
                    n_idx   = HdrBytes;
                    n_phase = PhData;
                end else begin
                    res.frame_abort = 1'b1;
                    n_phase = PhSrc;
                end
            end
            PhData: begin
                res.frame_byte = 1'b1;
                n_crc = crc_upd;
                n_idx = idx_inc;
                if (idx_inc >= ({1'b0, r_len} + HdrBytes)) begin
                    n_phase = PhCrcLo;
                end
            end
            PhCrcLo: begin
                res.frame_byte = 1'b1;
                n_crc_lo = i_rx_byte;
                n_phase  = PhCrcHi;
            end
            PhCrcHi: begin
                res.frame_byte  = 1'b1;
                res.frame_end   = 1'b1;
                res.crc_ok      = (r_crc == {i_rx_byte, r_crc_lo});
                res.frame_bytes = {1'b0, r_len} + Overhead;
                n_phase = PhSrc;
            end
            default: begin
                n_phase = PhSrc;
            end
        endcase
    end

    // parse state advances only on an accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PhSrc;
            r_len    <= '0;
            r_idx    <= '0;
            r_crc    <= CrcInit;
            r_crc_lo <= '0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_len    <= n_len;
            r_idx    <= n_idx;
            r_crc    <= n_crc;
            r_crc_lo <= n_crc_lo;
        end
    end

    assign o_result = res;

    // checks
    a_data_stays_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && r_phase == PhData |=> r_phase == PhData || r_phase == PhCrcLo)
        else $error("data phase left the frame early");

    a_crc_lo_then_hi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && r_phase == PhCrcLo |=> r_phase == PhCrcHi)
        else $error("CRC low byte not followed by high byte phase");

    a_index_in_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PhData |-> r_idx < ({1'b0, r_len} + HdrBytes))
        else $error("byte index ran past the payload");

endmodule

`default_nettype wire

// File: sv/cfpr_out_buf.sv
`default_nettype none

module cfpr_out_buf
    import cfpr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    output logic         o_accept,
    input  wire t_result i_result,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    output t_result      o_result
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    accept;
    logic    main_free;

    // input is taken whenever the skid slot is empty
    assign accept     = i_in_valid && !r_skid_valid;
    assign main_free  = !r_out_valid || !i_out_stall;
    assign o_accept   = accept;
    assign o_in_stall = r_skid_valid;

    // control: output register plus one skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (main_free) begin
                r_out_valid  <= r_skid_valid || accept;
                r_skid_valid <= 1'b0;
            end else if (accept) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (main_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (accept) begin
                r_out <= i_result;
            end
        end else if (accept) begin
            r_skid <= i_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    // checks
    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while output register empty");

    a_skid_drains_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid && !i_out_stall |=> !r_skid_valid && r_out_valid)
        else $error("skid entry not moved to output register");

    a_no_loss_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall && accept |=> r_skid_valid && r_out_valid)
        else $error("item accepted under stall was not kept");

endmodule

`default_nettype wire
